[sv/timed_register_write_sequencer_defines.svh]
`ifndef TIMED_REGISTER_WRITE_SEQUENCER_DEFINES_SVH
`define TIMED_REGISTER_WRITE_SEQUENCER_DEFINES_SVH

// condition holds at every clock edge out of reset
`define TRWS_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define TRWS_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

[sv/trws_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package trws_pkg;

  localparam int SongWords        = 4096;
  localparam int MaxWritesPerTick = 64;

  localparam int PtrW  = $clog2(SongWords);
  localparam int CntW  = $clog2(MaxWritesPerTick + 1);
  localparam int DataW = 16;
  localparam int AddrW = 12;

  localparam logic [CntW-1:0]  MaxWrites  = CntW'(MaxWritesPerTick);
  localparam logic [DataW-1:0] HdrMask    = 16'hFCFF;
  localparam logic [DataW-1:0] ByteStep   = 16'd4;
  localparam int               WaitShift  = 7;

  typedef enum logic [1:0] {
    OP_STORE = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_TICK  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ALU_INC  = 2'd0,
    ALU_SUB4 = 2'd1,
    ALU_DEC  = 2'd2
  } alu_op_e;

  typedef struct packed {
    op_e              operation;
    logic [AddrW-1:0] address;
    logic [DataW-1:0] word;
  } in_item_t;

  typedef struct packed {
    logic             write_valid;
    logic [DataW-1:0] chip_word;
    logic             last;
  } out_item_t;

  function automatic logic [DataW-1:0] hdr_count(input logic [DataW-1:0] hdr);
    logic [DataW-1:0] h;
    h = hdr & HdrMask;
    return {h[7:0], h[15:8]};
  endfunction

endpackage
`default_nettype wire

[sv/trws_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module trws_ram #(
  parameter int Width = 16,
  parameter int Depth = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

[sv/trws_alu.sv]
`timescale 1ns / 1ps
`default_nettype none
module trws_alu (
  input  wire trws_pkg::alu_op_e               op_i,
  input  wire logic [trws_pkg::DataW-1:0]      a_i,
  output logic      [trws_pkg::DataW-1:0]      y_o
);
  import trws_pkg::*;

  logic [DataW-1:0] b;

  always_comb begin
    case (op_i)
      ALU_INC:  b = DataW'(1);
      ALU_SUB4: b = DataW'(0) - ByteStep;
      ALU_DEC:  b = '1;
      default:  b = '0;
    endcase
  end

  assign y_o = a_i + b;

endmodule
`default_nettype wire

[sv/timed_register_write_sequencer.sv]
// store, stop and an idle tick: one result from ST_RESP after the input transfer
// start: header read in ST_HDR, then one result from ST_RESP
// tick: each chip write runs ST_CHECK (pointer step), ST_RD1 and ST_RD2 (song reads,
// shared adder) and ST_EMIT, up to 64 writes; input ready again after the last result
// reset: control state cleared, loop_enable set to 1, song memory left unwritten
`timescale 1ns / 1ps
`default_nettype none
module timed_register_write_sequencer (
  input  wire  logic               clk_i,
  input  wire  logic               rst_ni,
  input  wire  logic               in_valid_i,
  output logic                     in_ready_o,
  input  wire  trws_pkg::in_item_t in_item_i,
  output logic                     out_valid_o,
  input  wire  logic               out_ready_i,
  output trws_pkg::out_item_t      out_item_o,
  input  wire  logic               psel,
  input  wire  logic               penable,
  input  wire  logic               pwrite,
  input  wire  logic [1:0]         paddr,
  input  wire  logic [31:0]        pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  import trws_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_CHECK = 8'b0000_0010,
    ST_RD1   = 8'b0000_0100,
    ST_RD2   = 8'b0000_1000,
    ST_EMIT  = 8'b0001_0000,
    ST_FIN   = 8'b0010_0000,
    ST_HDR   = 8'b0100_0000,
    ST_RESP  = 8'b1000_0000
  } state_e;

  state_e           state_q, state_d;
  logic [PtrW-1:0]  ptr_q, ptr_d;
  logic [DataW-1:0] bytes_q, bytes_d;
  logic [DataW-1:0] wait_q, wait_d;
  logic             playing_q, playing_d;
  logic             loop_q;
  logic [CntW-1:0]  n_q, n_d;
  logic [DataW-1:0] w1_q, w1_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_item_q, out_item_d;

  alu_op_e          alu_op;
  logic [DataW-1:0] alu_a, alu_y;

  logic             ram_we;
  logic [PtrW-1:0]  ram_raddr;
  logic [DataW-1:0] ram_rdata;

  logic             in_xfer, out_free, more_due;

  assign pready     = 1'b1;
  assign prdata     = {31'b0, loop_q};
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign more_due   = (bytes_q != '0) && (wait_q == '0);
  assign ram_we     = in_xfer && (in_item_i.operation == OP_STORE);
  assign ram_raddr  = (state_q == ST_CHECK || state_q == ST_RD1) ? ptr_q : '0;

  trws_ram #(
    .Width(DataW),
    .Depth(SongWords)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(PtrW'(in_item_i.address)),
    .wdata_i(in_item_i.word),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  trws_alu u_alu (
    .op_i(alu_op),
    .a_i (alu_a),
    .y_o (alu_y)
  );

  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    bytes_d     = bytes_q;
    wait_d      = wait_q;
    playing_d   = playing_q;
    n_d         = n_q;
    w1_d        = w1_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_item_d  = out_item_q;
    alu_op      = ALU_INC;
    alu_a       = DataW'(ptr_q);
    in_ready_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          n_d = '0;
          case (in_item_i.operation)
            OP_START: state_d = ST_HDR;
            OP_STOP: begin
              playing_d = 1'b0;
              state_d   = ST_RESP;
            end
            OP_TICK: state_d = playing_q ? ST_CHECK : ST_RESP;
            default: state_d = ST_RESP;
          endcase
        end
      end
      ST_CHECK: begin
        if (more_due) begin
          ptr_d   = alu_y[PtrW-1:0];
          state_d = ST_RD1;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_RD1: begin
        w1_d    = ram_rdata;
        ptr_d   = alu_y[PtrW-1:0];
        state_d = ST_RD2;
      end
      ST_RD2: begin
        alu_op  = ALU_SUB4;
        alu_a   = bytes_q;
        bytes_d = alu_y;
        wait_d  = ram_rdata >> WaitShift;
        n_d     = n_q + CntW'(1);
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d            = 1'b1;
          out_item_d.write_valid = 1'b1;
          out_item_d.chip_word   = w1_q;
          out_item_d.last        = (n_q == MaxWrites) || !more_due;
          state_d = (n_q == MaxWrites && more_due) ? ST_IDLE : ST_CHECK;
        end
      end
      ST_FIN: begin
        alu_op  = ALU_DEC;
        alu_a   = wait_q;
        wait_d  = alu_y;
        state_d = (n_q == '0) ? ST_RESP : ST_IDLE;
        if (bytes_q == '0) begin
          wait_d = '0;
          if (loop_q) begin
            state_d = ST_HDR;
          end else begin
            playing_d = 1'b0;
          end
        end
      end
      ST_HDR: begin
        bytes_d   = hdr_count(ram_rdata);
        ptr_d     = PtrW'(1);
        wait_d    = '0;
        playing_d = 1'b1;
        state_d   = (n_q == '0) ? ST_RESP : ST_IDLE;
      end
      ST_RESP: begin
        if (out_free) begin
          out_valid_d            = 1'b1;
          out_item_d.write_valid = 1'b0;
          out_item_d.chip_word   = '0;
          out_item_d.last        = 1'b1;
          state_d                = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ptr_q       <= '0;
      bytes_q     <= '0;
      wait_q      <= '0;
      playing_q   <= 1'b0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
      loop_q      <= 1'b1;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      bytes_q     <= bytes_d;
      wait_q      <= wait_d;
      playing_q   <= playing_d;
      n_q         <= n_d;
      out_valid_q <= out_valid_d;
      if (psel && penable && pwrite && pready) begin
        loop_q <= pwdata[0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    w1_q       <= w1_d;
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
`default_nettype wire

[sv/trws_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "timed_register_write_sequencer_defines.svh"
module trws_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_i,
  input wire logic                out_valid_i,
  input wire logic                out_ready_i,
  input wire trws_pkg::out_item_t out_item_i,
  input wire logic                pready_i
);
  import trws_pkg::*;

  `TRWS_ASSERT_ALWAYS(a_pready_high, clk_i, rst_ni, pready_i, "pready low")
  `TRWS_ASSERT_ALWAYS(a_empty_result, clk_i, rst_ni, !out_valid_i || out_item_i.write_valid || (out_item_i.last && out_item_i.chip_word == '0), "malformed empty result")
  `TRWS_ASSERT_NEXT(a_busy_after_in, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i, "input ready right after a transfer")
  `TRWS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_item_i), "stalled result changed")

endmodule

bind timed_register_write_sequencer trws_checker u_trws_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_i (in_ready_o),
  .out_valid_i(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_item_i (out_item_o),
  .pready_i   (pready)
);
`default_nettype wire
